// ===== hw/rtl/byte_stream_reassembler_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the byte stream reassembler
// Clocked, reset-gated concurrent assertions used by the back-end RTL module.
// ----------------------------------------------------------------------------
`ifndef BYTE_STREAM_REASSEMBLER_ASSERT_SVH
`define BYTE_STREAM_REASSEMBLER_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define BSR_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// A condition that must hold in the cycle after the trigger.
`define BSR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/bsr_pkg.sv =====
// ----------------------------------------------------------------------------
// Byte stream reassembler package
// Payload types, the back-end state encoding and fixed field widths.
// ----------------------------------------------------------------------------
package bsr_pkg;

	localparam int BYTE_W = 8;
	localparam int WIN_W = 7;
	localparam int HELD_W = 7;
	localparam logic [WIN_W-1:0] WINDOW_RESET = 7'd64;
	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [31:0]       position;
		logic [BYTE_W-1:0] byte_value;
		logic              has_byte;
		logic              ends_stream;
	} item_t;

	typedef struct packed {
		logic              out_valid;
		logic [BYTE_W-1:0] out_byte;
		logic [31:0]       next_expected;
		logic [HELD_W-1:0] held_count;
		logic              stream_done;
		logic              last_of_run;
	} result_t;

	typedef struct packed {
		logic [BYTE_W-1:0] byte_value;
		logic              has_byte;
		logic              ends_stream;
	} flags_t;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_EVAL  = 4'b0010,
		S_CHECK = 4'b0100,
		S_EMIT  = 4'b1000
	} back_state_t;

endpackage

// ===== hw/rtl/bsr_front.sv =====
// ----------------------------------------------------------------------------
// Reassembler front end
// Takes an input beat, sizes its position and precomputes the position
// just past its payload, then pushes the packed entry into the queue.
// ----------------------------------------------------------------------------
module bsr_front import bsr_pkg::*; #(
	parameter int POSITION_BITS = 32
) (
	input  logic                                   item_valid,
	output logic                                   item_ready,
	input  item_t                                  item,
	output logic                                   push_valid,
	input  logic                                   push_ready,
	output logic [2*POSITION_BITS+$bits(flags_t):0] push_data
);

	logic [POSITION_BITS-1:0] pos;
	logic [POSITION_BITS:0]   pos_end;
	flags_t                   flags;

	// The end position is computed without wrap so the stale test can use it directly.
	assign pos = POSITION_BITS'(item.position);
	assign pos_end = {1'b0, pos} + (POSITION_BITS+1)'(item.has_byte);

	assign flags.byte_value = item.byte_value;
	assign flags.has_byte = item.has_byte;
	assign flags.ends_stream = item.ends_stream;

	assign push_data = {pos_end, pos, flags};
	assign push_valid = item_valid;
	assign item_ready = push_ready;

endmodule

// ===== hw/rtl/bsr_queue.sv =====
// ----------------------------------------------------------------------------
// Reassembler item queue
// Short FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module bsr_queue import bsr_pkg::*; #(
	parameter int DATA_W = 75,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_ready,
	input  logic [DATA_W-1:0] push_data,
	output logic              pop_valid,
	input  logic              pop_ready,
	output logic [DATA_W-1:0] pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] entry_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              push;
	logic              pop;

	assign push_ready = count_q != CNT_W'(DEPTH);
	assign pop_valid = count_q != '0;
	assign pop_data = entry_q[rd_ptr_q];
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			case ({push, pop})
				2'b10: count_q <= count_q + CNT_W'(1);
				2'b01: count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== hw/rtl/bsr_back.sv =====
// ----------------------------------------------------------------------------
// Reassembler back end
// Holds the window ring and stream state, stores one byte per item and
// releases contiguous bytes in order, one result beat per cycle while the result is not stalled.
// ----------------------------------------------------------------------------
`include "byte_stream_reassembler_assert.svh"

module bsr_back import bsr_pkg::*; #(
	parameter int WINDOW_DEPTH = 64,
	parameter int POSITION_BITS = 32
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [WIN_W-1:0]                       cfg_data,
	input  logic                                   pop_valid,
	output logic                                   pop_ready,
	input  logic [2*POSITION_BITS+$bits(flags_t):0] pop_data,
	output logic                                   result_valid,
	input  logic                                   result_ready,
	output result_t                                result
);

	localparam int P = POSITION_BITS;
	localparam int ADDR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int SUM_W = ADDR_W + 1;

	back_state_t state_q;

	// Item being worked on.
	logic [P:0]   pos_end_q;
	logic [P-1:0] pos_q;
	flags_t       flags_q;
	logic         stale_q;

	// Stream state.
	logic [WINDOW_DEPTH-1:0] marks_q;
	logic [BYTE_W-1:0]       byte_store_q [WINDOW_DEPTH];
	logic [BYTE_W-1:0]       rd_data_q;
	logic [P-1:0]            np_q;
	logic [ADDR_W-1:0]       head_q;
	logic [HELD_W-1:0]       held_q;
	logic                    end_known_q;
	logic [P-1:0]            end_pos_q;
	logic                    finished_q;
	logic [WIN_W-1:0]        window_q;

	logic    result_valid_q;
	result_t result_q;
	result_t result_d;

	logic [P:0]        pos_end_w;
	logic [P-1:0]      pos_w;
	flags_t            flags_w;
	logic [WIN_W-1:0]  win;
	logic              stale;
	logic              end_set;
	logic              end_known_n;
	logic [P-1:0]      end_pos_n;
	logic [P:0]        diff;
	logic              in_win;
	logic              past_end;
	logic [SUM_W-1:0]  slot_sum;
	logic [ADDR_W-1:0] slot;
	logic              do_store;
	logic              eval_at_end;
	logic              drain;
	logic              out_free;
	logic [P-1:0]      np_inc;
	logic [ADDR_W-1:0] head_inc;
	logic              at_end_next;
	logic              more;
	logic              emit;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;

	assign {pos_end_w, pos_w, flags_w} = pop_data;
	assign pop_ready = state_q == S_IDLE;

	// Evaluation of the item against the current window.
	assign win = (window_q > WIN_W'(WINDOW_DEPTH)) ? WIN_W'(WINDOW_DEPTH) : window_q;
	assign stale = pos_end_q < {1'b0, np_q};
	assign end_set = !stale && flags_q.ends_stream && !end_known_q;
	assign end_known_n = end_known_q || end_set;
	assign end_pos_n = end_set ? pos_end_q[P-1:0] : end_pos_q;
	assign diff = {1'b0, pos_q} - {1'b0, np_q};
	assign in_win = !diff[P] && (diff[P-1:WIN_W] == '0) && (diff[WIN_W-1:0] < win);
	assign past_end = end_known_n && (pos_q >= end_pos_n);
	assign slot_sum = {1'b0, head_q} + {1'b0, diff[ADDR_W-1:0]};
	assign slot = (slot_sum >= SUM_W'(WINDOW_DEPTH)) ?
		ADDR_W'(slot_sum - SUM_W'(WINDOW_DEPTH)) : slot_sum[ADDR_W-1:0];
	assign do_store = !stale && flags_q.has_byte && in_win && !past_end && !marks_q[slot];
	assign eval_at_end = end_known_n && (np_q == end_pos_n);

	// Release of the byte at the head of the ring.
	assign drain = !stale_q && marks_q[head_q] && !(end_known_q && (np_q == end_pos_q));
	assign out_free = !result_valid_q || result_ready;
	assign np_inc = np_q + P'(1);
	assign head_inc = (head_q == ADDR_W'(WINDOW_DEPTH - 1)) ? '0 : head_q + ADDR_W'(1);
	assign at_end_next = end_known_q && (np_inc == end_pos_q);
	assign more = marks_q[head_inc] && !at_end_next;

	assign emit = out_free && ((state_q == S_CHECK && !drain) || state_q == S_EMIT);
	assign rd_en = (state_q == S_CHECK && drain) || (state_q == S_EMIT && out_free && more);
	assign rd_addr = (state_q == S_CHECK) ? head_q : head_inc;

	always_comb begin
		if (state_q == S_EMIT) begin
			result_d.out_valid = 1'b1;
			result_d.out_byte = rd_data_q;
			result_d.next_expected = 32'(np_inc);
			result_d.held_count = held_q - HELD_W'(1);
			result_d.stream_done = finished_q || at_end_next;
			result_d.last_of_run = !more;
		end else begin
			result_d.out_valid = 1'b0;
			result_d.out_byte = '0;
			result_d.next_expected = 32'(np_q);
			result_d.held_count = held_q;
			result_d.stream_done = finished_q;
			result_d.last_of_run = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			stale_q <= 1'b0;
			marks_q <= '0;
			np_q <= '0;
			head_q <= '0;
			held_q <= '0;
			end_known_q <= 1'b0;
			end_pos_q <= '0;
			finished_q <= 1'b0;
			window_q <= WINDOW_RESET;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				window_q <= cfg_data;
			end
			if (emit) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (pop_valid) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					stale_q <= stale;
					if (end_set) begin
						end_known_q <= 1'b1;
						end_pos_q <= pos_end_q[P-1:0];
					end
					if (do_store) begin
						marks_q[slot] <= 1'b1;
						held_q <= held_q + HELD_W'(1);
					end
					if (!stale && eval_at_end) begin
						finished_q <= 1'b1;
					end
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (drain) begin
						state_q <= S_EMIT;
					end else if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						marks_q[head_q] <= 1'b0;
						held_q <= held_q - HELD_W'(1);
						np_q <= np_inc;
						head_q <= head_inc;
						if (at_end_next) begin
							finished_q <= 1'b1;
						end
						if (!more) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop_valid && pop_ready) begin
			pos_end_q <= pos_end_w;
			pos_q <= pos_w;
			flags_q <= flags_w;
		end
		if (emit) begin
			result_q <= result_d;
		end
	end

	// Window byte storage, one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (state_q == S_EVAL && do_store) begin
			byte_store_q[slot] <= flags_q.byte_value;
		end
		if (rd_en) begin
			rd_data_q <= byte_store_q[rd_addr];
		end
	end

	assign result_valid = result_valid_q;
	assign result = result_q;

	`BSR_ASSERT(held_matches_marks, held_q == HELD_W'($countones(marks_q)), "held count disagrees with marks")
	`BSR_ASSERT_NEXT(release_advances, state_q == S_EMIT && out_free, np_q == $past(np_q) + P'(1), "release did not advance position")
	`BSR_ASSERT(done_only_at_end, finished_q |-> (end_known_q && np_q == end_pos_q), "stream done away from end position")

endmodule

// ===== hw/rtl/byte_stream_reassembler.sv =====
// ----------------------------------------------------------------------------
// Byte stream reassembler
// Reorders position-tagged bytes through a window ring and releases them in
// stream order, tracking the end of the stream.
// ----------------------------------------------------------------------------
//  Channel   Handshake                   Beat
//  item      item_valid / item_ready     item_t: a byte, an end mark or both
//  result    result_valid / result_ready result_t: one released byte or status
//  cfg       cfg_valid / cfg_ready       window_size, always ready
//
//  An item passes the front end in its accept cycle and waits in a two-entry queue.
//  For each item the back end passes through S_IDLE, S_EVAL and S_CHECK, and through
//  S_EMIT once per released byte; the single read port of the byte store sets the pace
//  of one released byte per cycle while the result is not stalled.
//  Reset clears the valid marks at once; no clearing pass is needed.
//  A stalled result holds the back end; the queue keeps taking items until it fills.
// ----------------------------------------------------------------------------
module byte_stream_reassembler import bsr_pkg::*; #(
	parameter int WINDOW_DEPTH = 64,
	parameter int POSITION_BITS = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  item_t            item,
	output logic             result_valid,
	input  logic             result_ready,
	output result_t          result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [WIN_W-1:0] cfg_data
);

	localparam int ENTRY_W = 2 * POSITION_BITS + 1 + $bits(flags_t);

	logic               push_valid;
	logic               push_ready;
	logic [ENTRY_W-1:0] push_data;
	logic               pop_valid;
	logic               pop_ready;
	logic [ENTRY_W-1:0] pop_data;

	assign cfg_ready = 1'b1;

	bsr_front #(
		.POSITION_BITS(POSITION_BITS)
	) u_front (
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data(push_data)
	);

	bsr_queue #(
		.DATA_W(ENTRY_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data(push_data),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_data(pop_data)
	);

	bsr_back #(
		.WINDOW_DEPTH(WINDOW_DEPTH),
		.POSITION_BITS(POSITION_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_valid && cfg_ready),
		.cfg_data(cfg_data),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_data(pop_data),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

endmodule
